// ===== rtl/core/kplu_pkg.sv =====
`default_nettype none

package kplu_pkg;

  // Field widths of one beat and of the entry count
  localparam int unsigned KEY_W = 16;
  localparam int unsigned OFF_W = 8;
  localparam int unsigned IDX_W = 10;
  localparam int unsigned CNT_W = 11;

  // Opcodes of an input beat
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  // One stored kerning entry
  typedef struct packed {
    logic [KEY_W-1:0]        key;
    logic signed [OFF_W-1:0] offset;
  } entry_t;

  // Search sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_FIRST,
    S_LAST,
    S_PROBE,
    S_MATCH
  } state_e;

endpackage : kplu_pkg

`default_nettype wire

// ===== rtl/core/kerning_pair_lookup_unit.sv =====
`default_nettype none

// Kerning pair lookup unit.
//
// Command channel: a beat is taken on a rising edge with start high and busy
// low. Opcode load writes entry_index with pair_key and entry_offset in that
// cycle; busy stays low and no result follows. Opcode lookup binary-searches
// the first entry_count entries (saturated to TABLE_DEPTH) for pair_key.
// Configuration: cfg_we_i writes cfg_wdata_i into entry_count on the edge.
// Result channel: result_valid_o is high for exactly one cycle per lookup,
// with kern_offset_o and found_o; the receiver cannot stall it.
// Sequence: an empty table answers on the cycle after the beat, busy staying
// low. Otherwise busy holds through the first and last states, one probe state
// per probe (at most floor(log2(n)) + 1 probes, n the active count) and match,
// and the result shows in the first cycle with busy low. The search pace is set
// by the single registered read port of the entry table: each probe reads one
// entry and the next address follows from that compare.
// A key below the first key ends the search after one read, a key above the
// last key after two.
// Reset clears the sequencer, the result strobe and entry_count; the table
// holds no reset value and must be loaded before it is searched.
module kerning_pair_lookup_unit #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  start,
  output logic                                 busy,
  input  wire  [kplu_pkg::CNT_W-1:0]           cfg_wdata_i,
  input  wire                                  cfg_we_i,
  input  wire                                  opcode_i,
  input  wire  [kplu_pkg::IDX_W-1:0]           entry_index_i,
  input  wire  [kplu_pkg::KEY_W-1:0]           pair_key_i,
  input  wire  signed [kplu_pkg::OFF_W-1:0]    entry_offset_i,
  output logic                                 result_valid_o,
  output logic signed [kplu_pkg::OFF_W-1:0]    kern_offset_o,
  output logic                                 found_o
);
  import kplu_pkg::*;

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned XW = (CW > CNT_W) ? CW : CNT_W;
  localparam logic [XW-1:0] DEPTH_X = XW'(TABLE_DEPTH);

  // Entry table
  entry_t mem_q [TABLE_DEPTH];
  entry_t rd_q;
  logic [AW-1:0] raddr;
  logic          wr_en;

  // Control and search state
  state_e        state_q, state_d;
  logic [CNT_W-1:0] count_q;
  logic [CW-1:0] n_q, n_d;
  logic [CW-1:0] lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  logic [KEY_W-1:0] key_q, key_d;
  logic          res_valid_q, res_valid_d;
  logic          res_found_q, res_found_d;
  logic signed [OFF_W-1:0] res_off_q, res_off_d;

  logic          accept;
  logic [XW-1:0] count_x;
  logic [CW-1:0] lo_n, hi_n;
  logic [CW:0]   mid_sum;

  assign accept  = start && !busy;
  assign busy    = (state_q != S_IDLE);
  assign wr_en   = accept && (opcode_i == OP_LOAD) && (XW'(entry_index_i) < DEPTH_X);
  assign count_x = XW'(count_q);

  // Write one entry per load beat
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[AW'(entry_index_i)] <= '{key: pair_key_i, offset: entry_offset_i};
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rd_q <= mem_q[raddr];
  end

  // Probe update from the current read
  always_comb begin
    if (rd_q.key < key_q) begin
      lo_n = mid_q + CW'(1);
      hi_n = hi_q;
    end else begin
      lo_n = lo_q;
      hi_n = mid_q;
    end
    mid_sum = {1'b0, lo_n} + {1'b0, hi_n};
  end

  // Sequencer: next state, read address and result
  always_comb begin
    state_d     = state_q;
    n_d         = n_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    key_d       = key_q;
    raddr       = '0;
    res_valid_d = 1'b0;
    res_found_d = 1'b0;
    res_off_d   = '0;
    case (state_q)
      S_IDLE: begin
        if (accept && (opcode_i == OP_LOOKUP)) begin
          key_d = pair_key_i;
          n_d   = (count_x > DEPTH_X) ? CW'(TABLE_DEPTH) : CW'(count_x);
          if (n_d == '0) begin
            res_valid_d = 1'b1;
          end else begin
            state_d = S_FIRST;
          end
        end
      end
      S_FIRST: begin
        raddr = AW'(n_q - CW'(1));
        if (key_q < rd_q.key) begin
          res_valid_d = 1'b1;
          state_d     = S_IDLE;
        end else begin
          state_d = S_LAST;
        end
      end
      S_LAST: begin
        lo_d  = '0;
        hi_d  = n_q;
        mid_d = n_q >> 1;
        raddr = AW'(mid_d);
        if (key_q > rd_q.key) begin
          res_valid_d = 1'b1;
          state_d     = S_IDLE;
        end else begin
          state_d = S_PROBE;
        end
      end
      S_PROBE: begin
        lo_d = lo_n;
        hi_d = hi_n;
        if (lo_n < hi_n) begin
          mid_d = mid_sum[CW:1];
          raddr = AW'(mid_d);
        end else begin
          raddr   = AW'(lo_n);
          state_d = S_MATCH;
        end
      end
      S_MATCH: begin
        res_valid_d = 1'b1;
        if ((lo_q < n_q) && (rd_q.key == key_q)) begin
          res_found_d = 1'b1;
          res_off_d   = rd_q.offset;
        end
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
      if (cfg_we_i) begin
        count_q <= cfg_wdata_i;
      end
    end
  end

  // Search and result payload
  always_ff @(posedge clk_i) begin
    n_q         <= n_d;
    lo_q        <= lo_d;
    hi_q        <= hi_d;
    mid_q       <= mid_d;
    key_q       <= key_d;
    res_found_q <= res_found_d;
    res_off_q   <= res_off_d;
  end

  assign result_valid_o = res_valid_q;
  assign found_o        = res_valid_q && res_found_q;
  assign kern_offset_o  = res_valid_q ? res_off_q : '0;

  // Probe index stays inside the live interval
  a_probe_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PROBE) |-> ((lo_q <= mid_q) && (mid_q < hi_q) && (hi_q <= n_q)))
    else $error("probe index outside search interval");

  // A miss carries a zero offset
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !found_o) |-> (kern_offset_o == '0))
    else $error("miss with nonzero offset");

  // A result follows the match state, an early exit or an empty-table lookup, never mid-search
  a_result_timing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (($past(state_q) == S_MATCH) || ($past(state_q) == S_FIRST)
                        || ($past(state_q) == S_LAST) || ($past(state_q) == S_IDLE)))
    else $error("result strobe outside a search end");

  // Leaving the match state always produces a result
  a_match_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MATCH) |=> result_valid_o)
    else $error("search ended without result");

endmodule : kerning_pair_lookup_unit

`default_nettype wire

// ===== test/kerning_pair_lookup_unit_tb.sv =====
`default_nettype none

module kerning_pair_lookup_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import kplu_pkg::*;

  localparam int unsigned TABLE_DEPTH    = 1024;
  localparam int unsigned SETTLE_CYCLES  = 24;
  localparam int unsigned TAIL_CYCLES    = 30;
  localparam int unsigned WATCHDOG_LIMIT = 2000;

  // One lookup answer as it leaves the block
  typedef struct packed {
    logic signed [OFF_W-1:0] offset;
    logic                    found;
  } kern_result_t;

  // Mirror of the kerning table; predicts each lookup and checks the answers
  class kern_lookup_checker;
    entry_t       table_mem[TABLE_DEPTH];
    int unsigned  entry_count;
    kern_result_t pending_kerns[$];
    int unsigned  mismatches;

    function new();
      entry_count = 0;
      mismatches  = 0;
    endfunction

    function void set_entry_count(input int unsigned value);
      entry_count = value;
    endfunction

    // Binary search over the active entries, index 0 included
    function kern_result_t search_table(input logic [KEY_W-1:0] key);
      int unsigned  n;
      int unsigned  lo;
      int unsigned  hi;
      int unsigned  mid;
      kern_result_t res;
      res = '0;
      n = (entry_count > TABLE_DEPTH) ? TABLE_DEPTH : entry_count;
      if (n != 0 && key >= table_mem[0].key && key <= table_mem[n-1].key) begin
        lo = 0;
        hi = n;
        while (lo < hi) begin
          mid = lo + (hi - lo) / 2;
          if (table_mem[mid].key < key) lo = mid + 1;
          else hi = mid;
        end
        if (lo < n && table_mem[lo].key == key) begin
          res.offset = table_mem[lo].offset;
          res.found  = 1'b1;
        end
      end
      return res;
    endfunction

    // Store a load beat, queue the answer of a lookup beat
    function void note_beat(input logic op, input logic [IDX_W-1:0] idx,
                            input logic [KEY_W-1:0] key,
                            input logic signed [OFF_W-1:0] off);
      if (op == OP_LOAD) begin
        if (idx < TABLE_DEPTH) begin
          table_mem[idx].key    = key;
          table_mem[idx].offset = off;
        end
      end else begin
        pending_kerns.push_back(search_table(key));
      end
    endfunction

    // Compare one answer against the oldest queued lookup
    function void check_kern(input logic signed [OFF_W-1:0] got_offset,
                             input logic got_found);
      kern_result_t want;
      if (pending_kerns.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result: expected none, actual offset %0d found %0b",
                 $time, got_offset, got_found);
        return;
      end
      want = pending_kerns.pop_front();
      if (got_offset !== want.offset) begin
        mismatches++;
        $display("%0t: kern_offset mismatch: expected %0d, actual %0d",
                 $time, want.offset, got_offset);
      end
      if (got_found !== want.found) begin
        mismatches++;
        $display("%0t: found mismatch: expected %0b, actual %0b",
                 $time, want.found, got_found);
      end
    endfunction
  endclass

  logic                    clk_i          = 1'b0;
  logic                    rst_ni         = 1'b0;
  logic                    start          = 1'b0;
  logic                    busy;
  logic [CNT_W-1:0]        cfg_wdata_i    = '0;
  logic                    cfg_we_i       = 1'b0;
  logic                    opcode_i       = OP_LOAD;
  logic [IDX_W-1:0]        entry_index_i  = '0;
  logic [KEY_W-1:0]        pair_key_i     = '0;
  logic signed [OFF_W-1:0] entry_offset_i = '0;
  logic                    result_valid_o;
  logic signed [OFF_W-1:0] kern_offset_o;
  logic                    found_o;

  kern_lookup_checker kerns;
  int unsigned        stall_cycles = 0;
  bit                 gaps_on      = 1'b1;

  kerning_pair_lookup_unit #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .cfg_wdata_i   (cfg_wdata_i),
    .cfg_we_i      (cfg_we_i),
    .opcode_i      (opcode_i),
    .entry_index_i (entry_index_i),
    .pair_key_i    (pair_key_i),
    .entry_offset_i(entry_offset_i),
    .result_valid_o(result_valid_o),
    .kern_offset_o (kern_offset_o),
    .found_o       (found_o)
  );

  always #10 clk_i = ~clk_i;

  // Check answers; end the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) kerns.check_kern(kern_offset_o, found_o);
    if (!rst_ni || (start && !busy) || result_valid_o) begin
      stall_cycles <= 0;
    end else if (stall_cycles == WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Present one beat and hold it until the block takes it
  task automatic send_beat(input logic op, input logic [IDX_W-1:0] idx,
                           input logic [KEY_W-1:0] key,
                           input logic signed [OFF_W-1:0] off);
    start          <= 1'b1;
    opcode_i       <= op;
    entry_index_i  <= idx;
    pair_key_i     <= key;
    entry_offset_i <= off;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    kerns.note_beat(op, idx, key, off);
  endtask

  // Drop start for a random gap, mostly short
  task automatic idle_sender();
    int unsigned r;
    int unsigned gap;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 65) gap = 0;
    else if (r < 88) gap = $urandom_range(1, 3);
    else if (r < 97) gap = $urandom_range(4, 12);
    else gap = $urandom_range(20, 60);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Hold off until every queued lookup has answered
  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk_i); while (kerns.pending_kerns.size() != 0);
  endtask

  // Write entry_count once the block is idle
  task automatic write_entry_count(input int unsigned value);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value[CNT_W-1:0];
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    kerns.set_entry_count(value);
  endtask

  // Mostly lookups of stored keys, some order-keeping loads, a little noise
  task automatic run_phase(input int unsigned count, input int unsigned beats);
    int unsigned             n;
    int unsigned             r;
    int unsigned             idx;
    int unsigned             lo;
    int unsigned             hi;
    logic [KEY_W-1:0]        key;
    logic signed [OFF_W-1:0] off;
    write_entry_count(count);
    gaps_on = ($urandom_range(0, 3) != 0);
    n = (count > TABLE_DEPTH) ? TABLE_DEPTH : count;
    repeat (beats) begin
      off = OFF_W'($urandom_range(0, 255));
      if ($urandom_range(0, 3) == 0) begin
        idx = (n != 0 && $urandom_range(0, 4) != 0) ? $urandom_range(0, n - 1)
                                                     : $urandom_range(0, TABLE_DEPTH - 1);
        lo = (idx == 0) ? 0 : kerns.table_mem[idx-1].key;
        hi = (idx == TABLE_DEPTH - 1) ? 16'hFFFF : kerns.table_mem[idx+1].key;
        if ($urandom_range(0, 11) == 0) key = KEY_W'($urandom_range(0, 16'hFFFF));
        else if (lo <= hi) key = KEY_W'($urandom_range(hi, lo));
        else key = kerns.table_mem[idx].key;
        send_beat(OP_LOAD, idx[IDX_W-1:0], key, off);
      end else begin
        r = $urandom_range(0, 99);
        idx = (n != 0) ? $urandom_range(0, n - 1) : 0;
        if (n == 0 || r >= 92) begin
          key = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
          if (n == 0 && r < 80) key = KEY_W'($urandom_range(0, 16'hFFFF));
        end else if (r < 55) begin
          key = kerns.table_mem[idx].key;
        end else if (r < 75) begin
          key = $urandom_range(0, 1) ? kerns.table_mem[idx].key + 16'd1
                                     : kerns.table_mem[idx].key - 16'd1;
        end else if (r < 85) begin
          key = KEY_W'($urandom_range(0, 16'hFFFF));
        end else if (r < 88) begin
          key = kerns.table_mem[0].key;
          if (key != 0) key = key - 16'd1;
        end else begin
          key = kerns.table_mem[n-1].key;
          if (key != 16'hFFFF) key = key + 16'd1;
        end
        send_beat(OP_LOOKUP, IDX_W'($urandom_range(0, TABLE_DEPTH - 1)), key, off);
      end
      if ($urandom_range(0, 59) == 0) drain_results();
      else idle_sender();
    end
  endtask

  initial begin
    int unsigned key_acc;
    int unsigned step;
    kerns = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Empty table answers at once; loads give no answer
    write_entry_count(0);
    send_beat(OP_LOOKUP, '0, 16'h0000, '0);          idle_sender();
    send_beat(OP_LOOKUP, 10'h3FF, 16'hFFFF, 8'sh7F); idle_sender();
    send_beat(OP_LOAD, 10'd0, 16'h0010, -8'sd128);   idle_sender();
    send_beat(OP_LOAD, 10'd1, 16'h1234, 8'sd127);    idle_sender();
    send_beat(OP_LOAD, 10'd2, 16'h1234, 8'sd5);      idle_sender();
    send_beat(OP_LOAD, 10'd3, 16'hFF00, -8'sd1);     idle_sender();
    send_beat(OP_LOAD, 10'h3FF, 16'hFFFF, 8'sd0);    idle_sender();
    send_beat(OP_LOOKUP, '0, 16'h1234, '0);          idle_sender();

    // Four entries: first entry, equal keys, last entry, below, above, between
    write_entry_count(4);
    send_beat(OP_LOOKUP, '0, 16'h0010, '0); idle_sender();
    send_beat(OP_LOOKUP, '0, 16'h1234, '0); idle_sender();
    send_beat(OP_LOOKUP, '0, 16'hFF00, '0); idle_sender();
    send_beat(OP_LOOKUP, '0, 16'h0000, '0); idle_sender();
    send_beat(OP_LOOKUP, '0, 16'hFFFF, '0); idle_sender();
    send_beat(OP_LOOKUP, '0, 16'h1000, '0); idle_sender();
    send_beat(OP_LOOKUP, '0, 16'h0011, '0); idle_sender();

    // Single entry table
    write_entry_count(1);
    send_beat(OP_LOOKUP, '0, 16'h0010, '0); idle_sender();
    send_beat(OP_LOOKUP, '0, 16'h1234, '0); idle_sender();

    // Fill the whole table with ascending keys, some repeated
    key_acc = $urandom_range(0, 40);
    for (int unsigned i = 0; i < TABLE_DEPTH; i++) begin
      send_beat(OP_LOAD, i[IDX_W-1:0], key_acc[KEY_W-1:0], OFF_W'($urandom_range(0, 255)));
      idle_sender();
      step = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 110);
      key_acc = (key_acc + step > 16'hFFFF) ? 16'hFFFF : key_acc + step;
    end

    // Sweep the count through its extremes, saturation included
    run_phase(1024, 85);
    run_phase(1, 60);
    run_phase(2, 60);
    run_phase(2047, 85);
    run_phase($urandom_range(4, 64), 85);
    run_phase(0, 40);
    run_phase(1023, 85);
    run_phase($urandom_range(1025, 2046), 85);
    run_phase(3, 60);
    run_phase($urandom_range(65, 1022), 85);

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (kerns.mismatches == 0 && kerns.pending_kerns.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
